@@ rtl/pcf_pkg.sv @@
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared constants and beat types for the pivoted Cholesky factor block.
// ----------------------------------------------------------------------------
package pcf_pkg;

    localparam int MAX_ORDER = 8;
    localparam int FRAC_BITS = 16;

    localparam logic [3:0]  MATRIX_SIZE_RESET    = 4'd8;
    localparam logic [30:0] STOP_THRESHOLD_RESET = 31'd655;

    localparam logic [0:0] CFG_MATRIX_SIZE    = 1'b0;
    localparam logic [0:0] CFG_STOP_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [2:0]         row_index;
        logic [2:0]         col_index;
        logic signed [31:0] element_value;
        logic               load_done;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] factor_value;
        logic [2:0]         pivot_of_col;
        logic [3:0]         rank_found;
        logic               last_result;
    } out_beat_t;

endpackage

@@ rtl/pivoted_cholesky_factor.sv @@
// ----------------------------------------------------------------------------
// pivoted_cholesky_factor
// Loads a symmetric matrix in Q16.16 and runs a pivoted Cholesky factorization.
//
// Usage: the s_ channel carries one matrix element per beat, one beat per
// cycle while loading. The beat with load_done set is stored and starts the
// run; s_ready stays low until the last result beat has been taken. The run
// sorts the remaining diagonals with odd-even passes, takes a square root
// bit by bit, and for each remaining row reads the input, accumulates m dot
// terms through the one shared multiplier and divides bit by bit, then
// downdates. The factor is then sent column by column on the m_ channel,
// n beats per column; a stalled receiver simply holds the current beat.
// A run with zero rank sends one marker beat. Reset (aresetn low,
// synchronous) returns to the load state with default settings; matrix
// contents are kept undefined until written.
// ----------------------------------------------------------------------------
module pivoted_cholesky_factor #(
    parameter int MAX_ORDER = pcf_pkg::MAX_ORDER,
    parameter int FRAC_BITS = pcf_pkg::FRAC_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pcf_pkg::in_beat_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pcf_pkg::out_beat_t m_data,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [30:0]       cfg_data
);

    localparam int IDX_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CNT_W  = $clog2(MAX_ORDER + 1);
    localparam int DEPTH  = MAX_ORDER * MAX_ORDER;
    localparam int AW     = $clog2(DEPTH);
    localparam int SQ_W   = (32 + FRAC_BITS + 1) / 2;
    localparam int RAD_W  = 2 * SQ_W;
    localparam int DV_W   = 63;
    localparam int ITER_W = $clog2(DV_W + 1);
    localparam logic signed [63:0] NUMLIM = 64'sd1 <<< (62 - FRAC_BITS);
    localparam logic signed [63:0] RND    = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_INIT_RD   = 5'd1;
    localparam logic [4:0] ST_INIT_LD   = 5'd2;
    localparam logic [4:0] ST_SORT      = 5'd3;
    localparam logic [4:0] ST_CHECK     = 5'd4;
    localparam logic [4:0] ST_SQRT      = 5'd5;
    localparam logic [4:0] ST_SQRT_END  = 5'd6;
    localparam logic [4:0] ST_NUM_RD    = 5'd7;
    localparam logic [4:0] ST_NUM_LD    = 5'd8;
    localparam logic [4:0] ST_DOT_RD1   = 5'd9;
    localparam logic [4:0] ST_DOT_RD2   = 5'd10;
    localparam logic [4:0] ST_DOT_MUL   = 5'd11;
    localparam logic [4:0] ST_DOT_SUB   = 5'd12;
    localparam logic [4:0] ST_CLAMP     = 5'd13;
    localparam logic [4:0] ST_DIV       = 5'd14;
    localparam logic [4:0] ST_DIV_END   = 5'd15;
    localparam logic [4:0] ST_SQ_MUL    = 5'd16;
    localparam logic [4:0] ST_SQ_SUB    = 5'd17;
    localparam logic [4:0] ST_NEXT      = 5'd18;
    localparam logic [4:0] ST_OUT_START = 5'd19;
    localparam logic [4:0] ST_OUT_RD    = 5'd20;
    localparam logic [4:0] ST_OUT_LD    = 5'd21;
    localparam logic [4:0] ST_OUT_WAIT  = 5'd22;

    function automatic logic [AW-1:0] addr_of(input int r, input int c);
        addr_of = AW'(r * MAX_ORDER + c);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            sat32 = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    logic [4:0]         state_reg, state_next;
    logic [3:0]         msize_reg;
    logic [30:0]        thr_reg;
    logic [CNT_W-1:0]   n_reg, m_reg, i_reg, k_reg, pass_reg;
    logic signed [31:0] rd_reg [MAX_ORDER];
    logic [IDX_W-1:0]   po_reg [MAX_ORDER];
    logic [DEPTH-1:0]   fv_reg;
    logic signed [63:0] num_reg, prod_reg;
    logic signed [31:0] a_reg, lv_reg;
    logic [SQ_W-1:0]    ldiag_reg;
    logic [SQ_W:0]      srem_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [DV_W-1:0]    dvd_reg;
    logic [SQ_W-1:0]    drem_reg;
    logic               neg_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic               m_valid_reg;
    pcf_pkg::out_beat_t m_data_reg;

    logic               s_fire, in_range;
    logic [IDX_W-1:0]   piv, oth;
    logic signed [31:0] rd_m, rd_i;
    logic [CNT_W-1:0]   n_cfg;
    logic               a_we, f_we;
    logic [AW-1:0]      a_raddr, f_waddr, f_raddr;
    logic [31:0]        a_rdata, f_rdata, f_wdata;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] dot_term, num_sub, num_clamp, num_mag, sq_diff;
    logic [SQ_W+2:0]    sq_sh, sq_trial;
    logic [SQ_W:0]      dv_sh;
    logic signed [31:0] lv_calc;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign in_range = (int'(s_data.row_index) < MAX_ORDER) &&
                      (int'(s_data.col_index) < MAX_ORDER);
    assign piv  = po_reg[m_reg[IDX_W-1:0]];
    assign oth  = po_reg[i_reg[IDX_W-1:0]];
    assign rd_m = rd_reg[m_reg[IDX_W-1:0]];
    assign rd_i = rd_reg[i_reg[IDX_W-1:0]];

    always_comb begin
        if (msize_reg == 4'd0) begin
            n_cfg = CNT_W'(1);
        end else if (int'(msize_reg) > MAX_ORDER) begin
            n_cfg = CNT_W'(MAX_ORDER);
        end else begin
            n_cfg = CNT_W'(msize_reg);
        end
    end

    // memory addressing
    assign a_we    = s_fire && in_range;
    assign a_raddr = (state_reg == ST_INIT_RD) ? addr_of(int'(i_reg), int'(i_reg))
                                               : addr_of(int'(piv), int'(oth));
    assign f_we    = (state_reg == ST_SQRT_END) || (state_reg == ST_DIV_END);
    assign f_waddr = (state_reg == ST_SQRT_END) ? addr_of(int'(m_reg), int'(piv))
                                                : addr_of(int'(m_reg), int'(oth));
    assign f_wdata = (state_reg == ST_SQRT_END) ? 32'(ldiag_reg) : lv_calc;

    always_comb begin
        unique case (state_reg)
            ST_DOT_RD1: f_raddr = addr_of(int'(k_reg), int'(piv));
            ST_DOT_RD2: f_raddr = addr_of(int'(k_reg), int'(oth));
            default:    f_raddr = addr_of(int'(k_reg), int'(i_reg));
        endcase
    end

    pcf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_input_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (addr_of(int'(s_data.row_index), int'(s_data.col_index))),
        .wdata (s_data.element_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    pcf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_factor_ram (
        .aclk  (aclk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    // shared multiplier and arithmetic
    assign mul_a    = (state_reg == ST_DOT_MUL) ? a_reg : lv_reg;
    assign mul_b    = (state_reg == ST_DOT_MUL) ? $signed(f_rdata) : lv_reg;
    assign dot_term = (prod_reg + (prod_reg[63] ? RND : 64'sd0)) >>> FRAC_BITS;
    assign num_sub  = num_reg - dot_term;
    assign sq_diff  = 64'(rd_i) - (prod_reg >>> FRAC_BITS);

    always_comb begin
        if (num_reg > NUMLIM) begin
            num_clamp = NUMLIM;
        end else if (num_reg < -NUMLIM) begin
            num_clamp = -NUMLIM;
        end else begin
            num_clamp = num_reg;
        end
        num_mag = num_clamp[63] ? -num_clamp : num_clamp;
    end

    assign sq_sh    = {srem_reg, rad_reg[RAD_W-1 -: 2]};
    assign sq_trial = {1'b0, ldiag_reg, 2'b01};
    assign dv_sh    = {drem_reg, dvd_reg[DV_W-1]};

    always_comb begin
        if (neg_reg) begin
            lv_calc = (dvd_reg > DV_W'(33'h080000000)) ? 32'sh80000000
                                                       : $signed(~dvd_reg[31:0] + 32'd1);
        end else begin
            lv_calc = (dvd_reg > DV_W'(32'h7fffffff)) ? 32'sh7fffffff
                                                      : $signed(dvd_reg[31:0]);
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_fire && s_data.load_done) state_next = ST_INIT_RD;
            ST_INIT_RD:   state_next = ST_INIT_LD;
            ST_INIT_LD:   state_next = (i_reg + 1'b1 == n_reg) ? ST_SORT : ST_INIT_RD;
            ST_SORT:      if (pass_reg + 1'b1 == n_reg) state_next = ST_CHECK;
            ST_CHECK: begin
                state_next = ($signed({rd_m[31], rd_m}) > $signed({2'b00, thr_reg}))
                             ? ST_SQRT : ST_OUT_START;
            end
            ST_SQRT:      if (iter_reg == ITER_W'(SQ_W - 1)) state_next = ST_SQRT_END;
            ST_SQRT_END:  state_next = (m_reg + 1'b1 < n_reg) ? ST_NUM_RD : ST_NEXT;
            ST_NUM_RD:    state_next = ST_NUM_LD;
            ST_NUM_LD:    state_next = (m_reg == '0) ? ST_CLAMP : ST_DOT_RD1;
            ST_DOT_RD1:   state_next = ST_DOT_RD2;
            ST_DOT_RD2:   state_next = ST_DOT_MUL;
            ST_DOT_MUL:   state_next = ST_DOT_SUB;
            ST_DOT_SUB:   state_next = (k_reg + 1'b1 == m_reg) ? ST_CLAMP : ST_DOT_RD1;
            ST_CLAMP:     state_next = ST_DIV;
            ST_DIV:       if (iter_reg == ITER_W'(DV_W - 1)) state_next = ST_DIV_END;
            ST_DIV_END:   state_next = ST_SQ_MUL;
            ST_SQ_MUL:    state_next = ST_SQ_SUB;
            ST_SQ_SUB:    state_next = (i_reg + 1'b1 < n_reg) ? ST_NUM_RD : ST_NEXT;
            ST_NEXT:      state_next = (m_reg + 1'b1 < n_reg) ? ST_SORT : ST_OUT_START;
            ST_OUT_START: state_next = (m_reg == '0) ? ST_OUT_WAIT : ST_OUT_RD;
            ST_OUT_RD:    state_next = ST_OUT_LD;
            ST_OUT_LD:    state_next = ST_OUT_WAIT;
            ST_OUT_WAIT: begin
                if (m_ready) begin
                    state_next = m_data_reg.last_result ? ST_IDLE : ST_OUT_RD;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            msize_reg   <= pcf_pkg::MATRIX_SIZE_RESET;
            thr_reg     <= pcf_pkg::STOP_THRESHOLD_RESET;
            m_valid_reg <= 1'b0;
            fv_reg      <= '0;
            n_reg       <= CNT_W'(MAX_ORDER);
            m_reg       <= '0;
            i_reg       <= '0;
            k_reg       <= '0;
            pass_reg    <= '0;
            iter_reg    <= '0;
            for (int p = 0; p < MAX_ORDER; p++) begin
                rd_reg[p] <= '0;
                po_reg[p] <= IDX_W'(p);
            end
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_index)
                    pcf_pkg::CFG_MATRIX_SIZE:    msize_reg <= cfg_data[3:0];
                    pcf_pkg::CFG_STOP_THRESHOLD: thr_reg   <= cfg_data;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire && s_data.load_done) begin
                        n_reg  <= n_cfg;
                        m_reg  <= '0;
                        i_reg  <= '0;
                        fv_reg <= '0;
                        for (int p = 0; p < MAX_ORDER; p++) begin
                            po_reg[p] <= IDX_W'(p);
                        end
                    end
                end
                ST_INIT_LD: begin
                    rd_reg[i_reg[IDX_W-1:0]] <= $signed(a_rdata);
                    i_reg    <= i_reg + 1'b1;
                    pass_reg <= '0;
                end
                ST_SORT: begin
                    for (int p = 0; p < MAX_ORDER - 1; p++) begin
                        if ((p % 2) == int'(pass_reg[0]) && p >= int'(m_reg) &&
                            p + 1 < int'(n_reg) && rd_reg[p] < rd_reg[p+1]) begin
                            rd_reg[p]   <= rd_reg[p+1];
                            rd_reg[p+1] <= rd_reg[p];
                            po_reg[p]   <= po_reg[p+1];
                            po_reg[p+1] <= po_reg[p];
                        end
                    end
                    pass_reg <= pass_reg + 1'b1;
                end
                ST_CHECK: begin
                    rad_reg   <= RAD_W'({rd_m, {FRAC_BITS{1'b0}}});
                    srem_reg  <= '0;
                    ldiag_reg <= '0;
                    iter_reg  <= '0;
                    k_reg     <= '0;
                    i_reg     <= '0;
                end
                ST_SQRT: begin
                    if (sq_sh >= sq_trial) begin
                        srem_reg  <= (SQ_W+1)'(sq_sh - sq_trial);
                        ldiag_reg <= {ldiag_reg[SQ_W-2:0], 1'b1};
                    end else begin
                        srem_reg  <= (SQ_W+1)'(sq_sh);
                        ldiag_reg <= {ldiag_reg[SQ_W-2:0], 1'b0};
                    end
                    rad_reg  <= rad_reg << 2;
                    iter_reg <= iter_reg + 1'b1;
                end
                ST_SQRT_END: begin
                    fv_reg[addr_of(int'(m_reg), int'(piv))] <= 1'b1;
                    i_reg <= m_reg + 1'b1;
                end
                ST_NUM_LD: begin
                    num_reg <= 64'($signed(a_rdata));
                    k_reg   <= '0;
                end
                ST_DOT_RD2: a_reg <= $signed(f_rdata);
                ST_DOT_MUL, ST_SQ_MUL: prod_reg <= 64'(mul_a) * 64'(mul_b);
                ST_DOT_SUB: begin
                    num_reg <= num_sub;
                    k_reg   <= k_reg + 1'b1;
                end
                ST_CLAMP: begin
                    neg_reg  <= num_clamp[63];
                    dvd_reg  <= DV_W'(num_mag <<< FRAC_BITS);
                    drem_reg <= '0;
                    iter_reg <= '0;
                end
                ST_DIV: begin
                    if (dv_sh >= {1'b0, ldiag_reg}) begin
                        drem_reg <= SQ_W'(dv_sh - {1'b0, ldiag_reg});
                        dvd_reg  <= {dvd_reg[DV_W-2:0], 1'b1};
                    end else begin
                        drem_reg <= SQ_W'(dv_sh);
                        dvd_reg  <= {dvd_reg[DV_W-2:0], 1'b0};
                    end
                    iter_reg <= iter_reg + 1'b1;
                end
                ST_DIV_END: begin
                    lv_reg <= lv_calc;
                    fv_reg[addr_of(int'(m_reg), int'(oth))] <= 1'b1;
                end
                ST_SQ_SUB: begin
                    rd_reg[i_reg[IDX_W-1:0]] <= sat32(sq_diff);
                    i_reg <= i_reg + 1'b1;
                end
                ST_NEXT: begin
                    m_reg    <= m_reg + 1'b1;
                    pass_reg <= '0;
                end
                ST_OUT_START: begin
                    k_reg <= '0;
                    i_reg <= '0;
                    if (m_reg == '0) begin
                        m_data_reg  <= '{out_row: 3'd0, out_col: 3'd0, factor_value: 32'sd0,
                                         pivot_of_col: 3'd0, rank_found: 4'd0,
                                         last_result: 1'b1};
                        m_valid_reg <= 1'b1;
                    end
                end
                ST_OUT_LD: begin
                    m_data_reg.out_row      <= 3'(i_reg);
                    m_data_reg.out_col      <= 3'(k_reg);
                    m_data_reg.factor_value <= fv_reg[addr_of(int'(k_reg), int'(i_reg))]
                                               ? $signed(f_rdata) : 32'sd0;
                    m_data_reg.pivot_of_col <= 3'(po_reg[k_reg[IDX_W-1:0]]);
                    m_data_reg.rank_found   <= 4'(m_reg);
                    m_data_reg.last_result  <= (k_reg + 1'b1 == m_reg) &&
                                               (i_reg + 1'b1 == n_reg);
                    m_valid_reg <= 1'b1;
                end
                ST_OUT_WAIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (i_reg + 1'b1 == n_reg) begin
                            i_reg <= '0;
                            k_reg <= k_reg + 1'b1;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready while a result beat is pending");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (ldiag_reg != '0))
        else $error("divide by zero pivot");

    a_check_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> (m_reg < n_reg))
        else $error("pivot step beyond matrix order");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_result) |=> s_ready)
        else $error("block not idle after final beat");

endmodule

@@ rtl/pcf_ram.sv @@
// ----------------------------------------------------------------------------
// pcf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pcf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the pivoted Cholesky factor block: loads whole matrices of random,
// low-rank and extreme content over several sizes and thresholds, predicts
// every factor beat in fixed point and compares them in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    class cholesky_scoreboard;
        int          elem_store [64];
        int          factor_col [64];
        int          resid_diag [8];
        int unsigned pivot_seq [8];
        int unsigned order_n = 8;
        int unsigned eps = 655;
        pcf_pkg::out_beat_t pending_factor [$];
        int unsigned mismatches = 0;
        int unsigned beats_checked = 0;
        int unsigned runs = 0;

        function int sat_word(longint v);
            if (v > 64'sd2147483647) return 32'h7fffffff;
            if (v < -64'sd2147483648) return 32'h80000000;
            return int'(v);
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void run_factorization();
            longint err;
            longint num;
            longint sq;
            int unsigned m;
            int unsigned j;
            int unsigned key;
            int unsigned piv;
            int unsigned oth;
            int ldiag;
            int lv;
            pcf_pkg::out_beat_t b;
            m = 0;
            for (int i = 0; i < 64; i++) factor_col[i] = 0;
            for (int i = 0; i < 8; i++) pivot_seq[i] = i;
            for (int i = 0; i < order_n; i++) resid_diag[i] = elem_store[i * 9];
            err = resid_diag[0];
            for (int i = 1; i < order_n; i++)
                if (resid_diag[i] > err) err = resid_diag[i];
            while (err > longint'(eps) && m < order_n) begin
                for (int i = m + 1; i < order_n; i++) begin
                    key = pivot_seq[i];
                    j = i;
                    while (j > m && resid_diag[pivot_seq[j - 1]] < resid_diag[key]) begin
                        pivot_seq[j] = pivot_seq[j - 1];
                        j--;
                    end
                    pivot_seq[j] = key;
                end
                piv = pivot_seq[m];
                ldiag = int'(int_sqrt(longint'({32'd0, resid_diag[piv]})
                                      << pcf_pkg::FRAC_BITS));
                factor_col[m * 8 + piv] = ldiag;
                for (int i = m + 1; i < order_n; i++) begin
                    oth = pivot_seq[i];
                    num = elem_store[piv * 8 + oth];
                    for (int k = 0; k < m; k++)
                        num -= (longint'(factor_col[k * 8 + piv]) *
                                longint'(factor_col[k * 8 + oth])) / 65536;
                    if (num > (64'sd1 << 46)) num = 64'sd1 << 46;
                    if (num < -(64'sd1 << 46)) num = -(64'sd1 << 46);
                    lv = sat_word((num * 65536) / longint'(ldiag));
                    factor_col[m * 8 + oth] = lv;
                    sq = (longint'(lv) * longint'(lv)) / 65536;
                    resid_diag[oth] = sat_word(longint'(resid_diag[oth]) - sq);
                end
                m++;
                if (m < order_n) begin
                    err = resid_diag[pivot_seq[m]];
                    for (int i = m + 1; i < order_n; i++)
                        if (resid_diag[pivot_seq[i]] > err) err = resid_diag[pivot_seq[i]];
                end
            end
            if (m == 0) begin
                b = '0;
                b.last_result = 1'b1;
                pending_factor.push_back(b);
            end else begin
                for (int k = 0; k < m; k++)
                    for (int v = 0; v < order_n; v++) begin
                        b.out_row      = 3'(v);
                        b.out_col      = 3'(k);
                        b.factor_value = factor_col[k * 8 + v];
                        b.pivot_of_col = 3'(pivot_seq[k]);
                        b.rank_found   = 4'(m);
                        b.last_result  = (k + 1 == m && v + 1 == order_n);
                        pending_factor.push_back(b);
                    end
            end
            runs++;
        endfunction

        function void note_input(pcf_pkg::in_beat_t b);
            elem_store[b.row_index * 8 + b.col_index] = b.element_value;
            if (b.load_done) run_factorization();
        endfunction

        function void check_result(pcf_pkg::out_beat_t a);
            pcf_pkg::out_beat_t e;
            beats_checked++;
            if (pending_factor.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %p", a);
                return;
            end
            e = pending_factor.pop_front();
            if (a.out_row !== e.out_row || a.out_col !== e.out_col ||
                a.factor_value !== e.factor_value || a.pivot_of_col !== e.pivot_of_col ||
                a.rank_found !== e.rank_found || a.last_result !== e.last_result) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat mismatch: expected %p actual %p", e, a);
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 60000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    pcf_pkg::in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    pcf_pkg::out_beat_t m_data;
    logic      cfg_we = 1'b0;
    logic [0:0]  cfg_index = pcf_pkg::CFG_MATRIX_SIZE;
    logic [30:0] cfg_data = '0;

    cholesky_scoreboard sb = new();
    int unsigned items_sent = 0;
    int unsigned stall_cycles = 0;
    bit          no_idle = 0;
    bit          hold_req = 0;
    bit          hold_done = 0;
    int          mtx [8][8];

    pivoted_cholesky_factor dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                do @(posedge aclk); while (!m_valid);
                repeat (400) @(posedge aclk);
                hold_req = 0;
            end else if (no_idle || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
        end
    end

    task automatic send_beat(int r, int c, int v, bit done);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{row_index: 3'(r), col_index: 3'(c), element_value: v, load_done: done};
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic write_reg(logic [0:0] idx, logic [30:0] val);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_factor.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == pcf_pkg::CFG_MATRIX_SIZE) begin
            sb.order_n = (val[3:0] == 0) ? 1 : (val[3:0] > 8) ? 8 : val[3:0];
        end else begin
            sb.eps = val;
        end
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 0;
            3: return 1;
            4: return -1;
            default: return 32'h00010000;
        endcase
    endfunction

    // content: 0 well conditioned, 1 raw random, 2 extremes, 3 low rank
    task automatic load_matrix(int content);
        int unsigned n;
        int          pos [64];
        int          vec [8];
        int          t;
        int          j;
        n = sb.order_n;
        for (int i = 0; i < 8; i++) vec[i] = $urandom_range(0, 2 ** 19) - 2 ** 18;
        for (int r = 0; r < n; r++)
            for (int c = r; c < n; c++) begin
                case (content)
                    0: mtx[r][c] = (r == c) ? ($urandom_range(1, 64) << 16) + $urandom_range(0, 65535)
                                            : $urandom_range(0, 2 ** 18) - 2 ** 17;
                    1: mtx[r][c] = $urandom;
                    2: mtx[r][c] = pick_extreme();
                    default: mtx[r][c] = (longint'(vec[r]) * vec[c]) / 65536;
                endcase
                mtx[c][r] = (content == 1) ? $urandom : mtx[r][c];
            end
        for (int i = 0; i < n * n; i++) pos[i] = i;
        for (int i = n * n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = pos[i];
            pos[i] = pos[j];
            pos[j] = t;
        end
        for (int i = 0; i < n * n; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_beat($urandom_range(0, 7), $urandom_range(0, 7), $urandom, 1'b0);
            send_beat(pos[i] / n, pos[i] % n, mtx[pos[i] / n][pos[i] % n], i == n * n - 1);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        write_reg(pcf_pkg::CFG_MATRIX_SIZE, 31'd1);
        send_beat(0, 0, 32'h7fffffff, 1'b1);
        send_beat(0, 0, 32'h80000000, 1'b1);
        write_reg(pcf_pkg::CFG_MATRIX_SIZE, 31'd0);
        send_beat(0, 0, 32'h00010000, 1'b1);
        write_reg(pcf_pkg::CFG_MATRIX_SIZE, 31'd2);
        load_matrix(2);
        write_reg(pcf_pkg::CFG_STOP_THRESHOLD, 31'h7fffffff);
        load_matrix(0);
        write_reg(pcf_pkg::CFG_STOP_THRESHOLD, 31'd0);
        write_reg(pcf_pkg::CFG_MATRIX_SIZE, 31'd3);
        load_matrix(3);

        // random
        while (items_sent < 500) begin
            if (items_sent > 420) no_idle = 1;
            if (sb.runs >= 8 && !hold_done) begin
                hold_req  = 1;
                hold_done = 1;
            end
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 5))
                    0: write_reg(pcf_pkg::CFG_MATRIX_SIZE, 31'd8);
                    1: write_reg(pcf_pkg::CFG_MATRIX_SIZE, 31'd15);
                    default: write_reg(pcf_pkg::CFG_MATRIX_SIZE, 31'($urandom_range(1, 5)));
                endcase
                case ($urandom_range(0, 4))
                    0: write_reg(pcf_pkg::CFG_STOP_THRESHOLD, 31'd0);
                    1: write_reg(pcf_pkg::CFG_STOP_THRESHOLD, 31'd655);
                    2: write_reg(pcf_pkg::CFG_STOP_THRESHOLD, 31'h7fffffff);
                    default: write_reg(pcf_pkg::CFG_STOP_THRESHOLD,
                                       31'($urandom_range(0, 2 ** 22)));
                endcase
            end
            case ($urandom_range(0, 9))
                0: load_matrix(1);
                1: load_matrix(2);
                2, 3: load_matrix(3);
                default: load_matrix(0);
            endcase
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_factor.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("%0d beats sent, %0d factorizations over sizes 1..8, %0d result beats checked",
                 items_sent, sb.runs, sb.beats_checked);
        if (sb.mismatches == 0 && sb.pending_factor.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
